### rtl/udp_port_hop_nat_table_defines.svh
// Assertion macros for the port-hop NAT table
`ifndef UDP_PORT_HOP_NAT_TABLE_DEFINES_SVH
`define UDP_PORT_HOP_NAT_TABLE_DEFINES_SVH

// same-cycle implication
`define UPNAT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UPNAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/upnat_pkg.sv
package upnat_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [1:0] ACT_DROP      = 2'd0;
	localparam logic [1:0] ACT_TO_REMOTE = 2'd1;
	localparam logic [1:0] ACT_TO_CLIENT = 2'd2;
	localparam logic [1:0] ACT_RSVD      = 2'd3;

	localparam logic [2:0] REG_LOCAL_IP    = 3'd0;
	localparam logic [2:0] REG_REMOTE_IP   = 3'd1;
	localparam logic [2:0] REG_REMOTE_PORT = 3'd2;
	localparam logic [2:0] REG_LISTEN_LOW  = 3'd3;
	localparam logic [2:0] REG_LISTEN_HIGH = 3'd4;
	localparam logic [2:0] REG_ALLOC_LOW   = 3'd5;
	localparam logic [2:0] REG_ALLOC_HIGH  = 3'd6;

	localparam logic [15:0] LISTEN_LOW_RST = 16'd9000;
	localparam logic [15:0] LISTEN_HIGH_RST = 16'd9100;
	localparam logic [15:0] ALLOC_LOW_RST  = 16'd20000;
	localparam logic [15:0] ALLOC_HIGH_RST = 16'd30000;
	localparam logic [15:0] NEXT_PORT_RST  = 16'd20000;

	typedef enum logic [1:0] {
		PSEL_CPORT = 2'd0,
		PSEL_NEXT  = 2'd1,
		PSEL_DPORT = 2'd2
	} psel_t;

	typedef enum logic [1:0] {
		MODE_NEW   = 2'd0,
		MODE_KNOWN = 2'd1,
		MODE_BACK  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] remote_ip;
		logic [15:0] remote_port;
		logic [15:0] listen_low;
		logic [15:0] listen_high;
		logic [15:0] alloc_low;
		logic [15:0] alloc_high;
	} cfg_t;

	typedef struct packed {
		logic  load;
		logic  scan_run;
		logic  rscan_start;
		psel_t psel;
		logic  alloc;
		logic  full_set;
		logic  finish;
		mode_t mode;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic c_hit;
		logic c_free;
		logic new_ok;
	} stat_t;

endpackage

### rtl/upnat_ctrl.sv
module upnat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  upnat_pkg::stat_t stat,
	output upnat_pkg::cmd_t  cmd
);
	import upnat_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CSCAN  = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_RSCAN  = 5'b01000,
		ST_WRITE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_BACK;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		mode_d          = mode_q;
		cmd             = '0;
		cmd.psel        = PSEL_DPORT;
		cmd.mode        = mode_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CSCAN;
				end
			end
			ST_CSCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.rscan_start = 1'b1;
				state_d         = ST_RSCAN;
				priority if (stat.c_hit) begin
					cmd.psel = PSEL_CPORT;
					mode_d   = MODE_KNOWN;
				end else if (stat.new_ok && stat.c_free) begin
					cmd.psel  = PSEL_NEXT;
					cmd.alloc = 1'b1;
					mode_d    = MODE_NEW;
				end else if (stat.new_ok) begin
					cmd.full_set = 1'b1;
					mode_d       = MODE_BACK;
				end else begin
					mode_d = MODE_BACK;
				end
			end
			ST_RSCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/upnat_dp.sv
module upnat_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  upnat_pkg::cfg_t   cfg,
	input  upnat_pkg::cmd_t   cmd,
	output upnat_pkg::stat_t  stat,
	input  logic [31:0]       src_ip,
	input  logic [31:0]       dst_ip,
	input  logic [15:0]       src_port,
	input  logic [15:0]       dst_port,
	output logic              done,
	output logic [1:0]        action,
	output logic [31:0]       out_src_ip,
	output logic [31:0]       out_dst_ip,
	output logic [15:0]       out_src_port,
	output logic [15:0]       out_dst_port,
	output logic              new_connection,
	output logic              table_full
);
	import upnat_pkg::*;

	logic [47:0] ckey_mem [ENTRIES];
	logic [15:0] cport_mem [ENTRIES];
	logic [15:0] rkey_mem [ENTRIES];
	logic [31:0] rsip_mem [ENTRIES];
	logic [31:0] rdip_mem [ENTRIES];
	logic [15:0] rsport_mem [ENTRIES];
	logic [15:0] rdport_mem [ENTRIES];

	logic [ENTRIES-1:0] cvalid_q, rvalid_q;

	logic [31:0] sip_q, dip_q;
	logic [15:0] sport_q, dport_q;
	logic [15:0] next_port_q, scan_port_q, c_port_q;

	logic [CNT_W-1:0] cnt_q;
	logic             rd_v_s1, tbl_reply_q;
	logic [IDX_W-1:0] idx_s1;
	logic [47:0]      ckey_s1;
	logic [15:0]      cport_s1, rkey_s1, rsport_s1, rdport_s1;
	logic [31:0]      rsip_s1, rdip_s1;

	logic             c_hit_q, c_free_q, r_hit_q, r_free_q;
	logic [IDX_W-1:0] c_free_idx_q, r_idx_q, r_free_idx_q;
	logic [31:0]      r_sip_q, r_dip_q;
	logic [15:0]      r_sport_q, r_dport_q;
	logic             new_q, full_q;

	logic [IDX_W-1:0] rd_idx, rw_idx;
	logic             scanning, entry_valid;
	logic [16:0]      next_inc;
	logic [15:0]      port_pick;

	assign rd_idx      = cnt_q[IDX_W-1:0];
	assign scanning    = cmd.scan_run && (cnt_q != CNT_W'(ENTRIES));
	assign entry_valid = tbl_reply_q ? rvalid_q[idx_s1] : cvalid_q[idx_s1];
	assign next_inc    = {1'b0, next_port_q} + 17'd1;
	assign rw_idx      = r_hit_q ? r_idx_q : r_free_idx_q;

	always_comb begin
		unique case (cmd.psel)
			PSEL_CPORT: port_pick = c_port_q;
			PSEL_NEXT:  port_pick = next_port_q;
			PSEL_DPORT: port_pick = dport_q;
			default:    port_pick = dport_q;
		endcase
	end

	assign stat.scan_done = (cnt_q == CNT_W'(ENTRIES)) && !rd_v_s1;
	assign stat.c_hit     = c_hit_q;
	assign stat.c_free    = c_free_q;
	assign stat.new_ok    = (dport_q >= cfg.listen_low) && (dport_q <= cfg.listen_high)
		&& (dip_q == cfg.local_ip);

	always_ff @(posedge clk) begin
		if (scanning) begin
			ckey_s1   <= ckey_mem[rd_idx];
			cport_s1  <= cport_mem[rd_idx];
			rkey_s1   <= rkey_mem[rd_idx];
			rsip_s1   <= rsip_mem[rd_idx];
			rdip_s1   <= rdip_mem[rd_idx];
			rsport_s1 <= rsport_mem[rd_idx];
			rdport_s1 <= rdport_mem[rd_idx];
		end
		if (cmd.alloc) begin
			ckey_mem[c_free_idx_q]  <= {sip_q, sport_q};
			cport_mem[c_free_idx_q] <= next_port_q;
		end
		if (cmd.finish && cmd.mode == MODE_NEW && (r_hit_q || r_free_q)) begin
			rkey_mem[rw_idx]   <= c_port_q;
			rsip_mem[rw_idx]   <= dip_q;
			rdip_mem[rw_idx]   <= sip_q;
			rsport_mem[rw_idx] <= dport_q;
			rdport_mem[rw_idx] <= sport_q;
		end else if (cmd.finish && cmd.mode == MODE_KNOWN && r_hit_q) begin
			rsport_mem[r_idx_q] <= dport_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sip_q   <= src_ip;
			dip_q   <= dst_ip;
			sport_q <= src_port;
			dport_q <= dst_port;
		end
		if (cmd.rscan_start) scan_port_q <= port_pick;
		if (scanning) idx_s1 <= rd_idx;
		if (cmd.alloc) c_port_q <= next_port_q;
		else if (rd_v_s1 && !tbl_reply_q && entry_valid && !c_hit_q && ckey_s1 == {sip_q, sport_q})
			c_port_q <= cport_s1;
		if (rd_v_s1 && !tbl_reply_q && !entry_valid && !c_free_q) c_free_idx_q <= idx_s1;
		if (rd_v_s1 && tbl_reply_q && entry_valid && !r_hit_q && rkey_s1 == scan_port_q) begin
			r_idx_q   <= idx_s1;
			r_sip_q   <= rsip_s1;
			r_dip_q   <= rdip_s1;
			r_sport_q <= rsport_s1;
			r_dport_q <= rdport_s1;
		end
		if (rd_v_s1 && tbl_reply_q && !entry_valid && !r_free_q) r_free_idx_q <= idx_s1;
		if (cmd.finish) begin
			unique case (cmd.mode)
				MODE_NEW, MODE_KNOWN: begin
					action       <= ACT_TO_REMOTE;
					out_src_ip   <= cfg.local_ip;
					out_dst_ip   <= cfg.remote_ip;
					out_src_port <= c_port_q;
					out_dst_port <= cfg.remote_port;
				end
				default: begin
					action       <= r_hit_q ? ACT_TO_CLIENT : ACT_DROP;
					out_src_ip   <= r_hit_q ? r_sip_q : 32'd0;
					out_dst_ip   <= r_hit_q ? r_dip_q : 32'd0;
					out_src_port <= r_hit_q ? r_sport_q : 16'd0;
					out_dst_port <= r_hit_q ? r_dport_q : 16'd0;
				end
			endcase
			new_connection <= new_q;
			table_full     <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q    <= '0;
			rvalid_q    <= '0;
			next_port_q <= NEXT_PORT_RST;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			tbl_reply_q <= 1'b0;
			c_hit_q     <= 1'b0;
			c_free_q    <= 1'b0;
			r_hit_q     <= 1'b0;
			r_free_q    <= 1'b0;
			new_q       <= 1'b0;
			full_q      <= 1'b0;
			done        <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.load) begin
				cnt_q       <= '0;
				rd_v_s1     <= 1'b0;
				tbl_reply_q <= 1'b0;
				c_hit_q     <= 1'b0;
				c_free_q    <= 1'b0;
				new_q       <= 1'b0;
				full_q      <= 1'b0;
			end else if (cmd.rscan_start) begin
				cnt_q       <= '0;
				rd_v_s1     <= 1'b0;
				tbl_reply_q <= 1'b1;
				r_hit_q     <= 1'b0;
				r_free_q    <= 1'b0;
			end else begin
				rd_v_s1 <= scanning;
				if (scanning) cnt_q <= cnt_q + CNT_W'(1);
				if (rd_v_s1 && !tbl_reply_q && entry_valid && ckey_s1 == {sip_q, sport_q})
					c_hit_q <= 1'b1;
				if (rd_v_s1 && !tbl_reply_q && !entry_valid) c_free_q <= 1'b1;
				if (rd_v_s1 && tbl_reply_q && entry_valid && rkey_s1 == scan_port_q)
					r_hit_q <= 1'b1;
				if (rd_v_s1 && tbl_reply_q && !entry_valid) r_free_q <= 1'b1;
			end
			if (cmd.alloc) begin
				cvalid_q[c_free_idx_q] <= 1'b1;
				new_q                  <= 1'b1;
				next_port_q <= (next_inc > {1'b0, cfg.alloc_high}) ? cfg.alloc_low
					: next_inc[15:0];
			end
			if (cmd.full_set) full_q <= 1'b1;
			if (cmd.finish && cmd.mode == MODE_NEW && (r_hit_q || r_free_q))
				rvalid_q[rw_idx] <= 1'b1;
		end
	end

endmodule

### rtl/udp_port_hop_nat_table.sv
// channel   direction  transaction
// packet    in         start high while busy low; src_ip, dst_ip, src_port, dst_port
// result    out        done high for one cycle; action, out_* fields, flags
// config    in         cfg_valid and cfg_ready high; cfg_index selects, cfg_data
//
// One packet goes from accept to done through two sequential scans over the
// 64-entry client and reply memories, one read per cycle, each 64 reads and a
// drain, with a decide state between the scans and a write state after them.
// A new packet may be accepted in the cycle done is high.
// Reset clears valid bits and control registers at once; no clearing pass.
// The receiver cannot stall; cfg_ready is always high.
module udp_port_hop_nat_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	output logic        done,
	output logic [1:0]  action,
	output logic [31:0] out_src_ip,
	output logic [31:0] out_dst_ip,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic        new_connection,
	output logic        table_full,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import upnat_pkg::*;
	`include "udp_port_hop_nat_table_defines.svh"

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip    <= '0;
			cfg_q.remote_ip   <= '0;
			cfg_q.remote_port <= '0;
			cfg_q.listen_low  <= LISTEN_LOW_RST;
			cfg_q.listen_high <= LISTEN_HIGH_RST;
			cfg_q.alloc_low   <= ALLOC_LOW_RST;
			cfg_q.alloc_high  <= ALLOC_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOCAL_IP:    cfg_q.local_ip    <= cfg_data;
				REG_REMOTE_IP:   cfg_q.remote_ip   <= cfg_data;
				REG_REMOTE_PORT: cfg_q.remote_port <= cfg_data[15:0];
				REG_LISTEN_LOW:  cfg_q.listen_low  <= cfg_data[15:0];
				REG_LISTEN_HIGH: cfg_q.listen_high <= cfg_data[15:0];
				REG_ALLOC_LOW:   cfg_q.alloc_low   <= cfg_data[15:0];
				REG_ALLOC_HIGH:  cfg_q.alloc_high  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	upnat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	upnat_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.stat           (stat),
		.src_ip         (src_ip),
		.dst_ip         (dst_ip),
		.src_port       (src_port),
		.dst_port       (dst_port),
		.done           (done),
		.action         (action),
		.out_src_ip     (out_src_ip),
		.out_dst_ip     (out_dst_ip),
		.out_src_port   (out_src_port),
		.out_dst_port   (out_dst_port),
		.new_connection (new_connection),
		.table_full     (table_full)
	);

	`UPNAT_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	`UPNAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not start work")
	`UPNAT_ASSERT_NOW(a_act_code, done, action != ACT_RSVD, "reserved action code")
	`UPNAT_ASSERT_NOW(a_full_new, done && table_full, !new_connection, "full and new together")

endmodule
